[sv/dnd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants for the nucleotide decoder.
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int DND_BAD_COUNT_BITS = 16;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int CFG_DATA_BITS      = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_MAP      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMPLEMENT_ON = 1'd1;

    localparam logic [7:0] BASE_MAP_RESET = 8'd228;

    // Letter codes
    localparam logic [1:0] LETTER_A = 2'd0;
    localparam logic [1:0] LETTER_T = 2'd1;
    localparam logic [1:0] LETTER_G = 2'd2;
    localparam logic [1:0] LETTER_C = 2'd3;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_PADDED = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SYM_BLANK = 2'd0,
        SYM_BASE  = 2'd1,
        SYM_BAD   = 2'd2
    } t_sym_class;

    // Classified request held between the front stage and the packer
    typedef struct packed {
        logic       valid;
        logic       eos;
        t_sym_class cls;
        logic [1:0] pair;
    } t_front;

endpackage

`default_nettype wire

[sv/dnd_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_in_if
// Input channel: one text byte or an end-of-stream marker per request.
// ----------------------------------------------------------------------------
interface dnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_stream;

    modport source (output valid, output symbol, output end_of_stream, input ready);
    modport sink   (input valid, input symbol, input end_of_stream, output ready);
endinterface

`default_nettype wire

[sv/dnd_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_out_if
// Output channel: packed bytes and end-of-stream reports.
// ----------------------------------------------------------------------------
interface dnd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [1:0]  kind;
    logic [1:0]  partial_count;
    logic [15:0] invalid_total;

    modport source (output valid, output byte_value, output kind, output partial_count,
                    output invalid_total, input ready);
    modport sink   (input valid, input byte_value, input kind, input partial_count,
                    input invalid_total, output ready);
endinterface

`default_nettype wire

[sv/dnd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_front
// Input register and character classification (blank, base with its pair
// value, or invalid).
// ----------------------------------------------------------------------------
module dnd_front
    import dnd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_eos,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_base_map,
    input  wire logic       i_complement_on,
    output logic            o_ready,
    output t_front          o_front
);

    logic       r_valid;
    logic [7:0] r_symbol;
    logic       r_eos;

    logic       is_blank;
    logic       is_letter;
    logic [1:0] code;
    logic [1:0] pair;
    logic       found;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_symbol <= i_symbol;
            r_eos    <= i_eos;
        end
    end

    always_comb begin
        is_blank  = (r_symbol == 8'h20) || (r_symbol >= 8'h09 && r_symbol <= 8'h0D);
        is_letter = 1'b1;
        unique case (r_symbol)
            "A", "a": code = LETTER_A;
            "T", "t": code = LETTER_T;
            "G", "g": code = LETTER_G;
            "C", "c": code = LETTER_C;
            default: begin
                code      = LETTER_A;
                is_letter = 1'b0;
            end
        endcase
        // A<->T and G<->C differ only in the low bit
        if (i_complement_on) begin
            code = code ^ 2'b01;
        end

        // lowest matching pair wins
        found = 1'b0;
        pair  = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (i_base_map[2*i +: 2] == code) begin
                found = 1'b1;
                pair  = 2'(i);
            end
        end

        o_front.valid = r_valid;
        o_front.eos   = r_eos;
        o_front.pair  = pair;
        if (is_blank) begin
            o_front.cls = SYM_BLANK;
        end else if (is_letter && found) begin
            o_front.cls = SYM_BASE;
        end else begin
            o_front.cls = SYM_BAD;
        end
    end

endmodule

`default_nettype wire

[sv/dnd_pack.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pack
// Pending-pair accumulator, saturating invalid counter and result register.
// ----------------------------------------------------------------------------
module dnd_pack
    import dnd_pkg::*;
#(
    parameter int BAD_COUNT_BITS = DND_BAD_COUNT_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_front i_front,
    input  wire logic   i_out_ready,
    output logic        o_advance,
    output logic        o_valid,
    output logic [7:0]  o_byte_value,
    output t_kind       o_kind,
    output logic [1:0]  o_partial_count,
    output logic [15:0] o_invalid_total
);

    logic [5:0]                r_pending_bits;
    logic [1:0]                r_pending_count;
    logic [BAD_COUNT_BITS-1:0] r_bad_count;
    logic                      r_out_valid;
    logic [7:0]                r_byte_value;
    t_kind                     r_kind;
    logic [1:0]                r_partial_count;
    logic [15:0]               r_invalid_total;

    logic [5:0]                n_pending_bits;
    logic [1:0]                n_pending_count;
    logic [BAD_COUNT_BITS-1:0] n_bad_count;
    logic                      fire;
    logic                      emit;
    logic [7:0]                n_byte_value;
    t_kind                     n_kind;
    logic [1:0]                n_partial_count;
    logic [31:0]               bad_wide;
    logic [15:0]               total;

    assign o_advance = !r_out_valid || i_out_ready;
    assign fire      = i_front.valid && o_advance;

    always_comb begin
        bad_wide = 32'(r_bad_count);
        total    = (bad_wide > 32'h0000_FFFF) ? 16'hFFFF : bad_wide[15:0];

        n_pending_bits  = r_pending_bits;
        n_pending_count = r_pending_count;
        n_bad_count     = r_bad_count;
        emit            = 1'b0;
        n_byte_value    = 8'd0;
        n_kind          = KIND_FULL;
        n_partial_count = 2'd0;

        if (i_front.eos) begin
            emit            = 1'b1;
            n_pending_bits  = 6'd0;
            n_pending_count = 2'd0;
            n_bad_count     = '0;
            n_partial_count = r_pending_count;
            n_kind          = KIND_PADDED;
            unique case (r_pending_count)
                2'd0: begin
                    n_kind = KIND_END;
                end
                2'd1: n_byte_value = {r_pending_bits[1:0], 6'd0};
                2'd2: n_byte_value = {r_pending_bits[3:0], 4'd0};
                2'd3: n_byte_value = {r_pending_bits, 2'd0};
                default: n_byte_value = 8'd0;
            endcase
        end else begin
            unique case (i_front.cls)
                SYM_BASE: begin
                    if (r_pending_count == 2'd3) begin
                        emit            = 1'b1;
                        n_byte_value    = {r_pending_bits, i_front.pair};
                        n_pending_bits  = 6'd0;
                        n_pending_count = 2'd0;
                    end else begin
                        n_pending_bits  = {r_pending_bits[3:0], i_front.pair};
                        n_pending_count = r_pending_count + 2'd1;
                    end
                end
                SYM_BAD: begin
                    if (r_bad_count != '1) begin
                        n_bad_count = r_bad_count + BAD_COUNT_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_bits  <= 6'd0;
            r_pending_count <= 2'd0;
            r_bad_count     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (fire) begin
                r_pending_bits  <= n_pending_bits;
                r_pending_count <= n_pending_count;
                r_bad_count     <= n_bad_count;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire && emit) begin
            r_byte_value    <= n_byte_value;
            r_kind          <= n_kind;
            r_partial_count <= n_partial_count;
            r_invalid_total <= total;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_value    = r_byte_value;
    assign o_kind          = r_kind;
    assign o_partial_count = r_partial_count;
    assign o_invalid_total = r_invalid_total;

endmodule

`default_nettype wire

[sv/dna_nucleotide_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dna_nucleotide_decoder_unit
// Text-to-2-bit nucleotide packer with end-of-stream flush.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one request per cycle while in_ch.ready is high: a character
//   byte, or end_of_stream=1. Whitespace is dropped silently; other non-base
//   bytes bump a saturating invalid count. Every fourth base gives a full byte
//   on out_ch; an end-of-stream request gives a padded byte or a plain end
//   report and then clears pending pairs and the invalid count.
//   The user writes configuration (base_map, complement_on) through i_cfg_we,
//   i_cfg_index and i_cfg_data while the unit is idle; nothing enforces this.
// Timing:
//   A request accepted into the input register is classified and packed, and
//   its result is loaded into the output register when the pack stage
//   advances. Throughput is one request per cycle while out_ch is not stalled.
//   When out_ch stalls, the output register holds and the pipeline keeps
//   flowing until one more request waits in the input register; in_ch.ready
//   then drops. Synchronous reset empties both stages, clears the pending
//   state and restores the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module dna_nucleotide_decoder_unit
    import dnd_pkg::*;
#(
    parameter int BAD_COUNT_BITS = DND_BAD_COUNT_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    dnd_in_if.sink                         in_ch,
    dnd_out_if.source                      out_ch,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [7:0] r_base_map;
    logic       r_complement_on;
    t_front     front;
    logic       advance;
    t_kind      kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_map      <= BASE_MAP_RESET;
            r_complement_on <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_MAP:      r_base_map      <= i_cfg_data;
                CFG_COMPLEMENT_ON: r_complement_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dnd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_ch.valid),
        .i_symbol        (in_ch.symbol),
        .i_eos           (in_ch.end_of_stream),
        .i_advance       (advance),
        .i_base_map      (r_base_map),
        .i_complement_on (r_complement_on),
        .o_ready         (in_ch.ready),
        .o_front         (front)
    );

    dnd_pack #(
        .BAD_COUNT_BITS (BAD_COUNT_BITS)
    ) u_pack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_front         (front),
        .i_out_ready     (out_ch.ready),
        .o_advance       (advance),
        .o_valid         (out_ch.valid),
        .o_byte_value    (out_ch.byte_value),
        .o_kind          (kind),
        .o_partial_count (out_ch.partial_count),
        .o_invalid_total (out_ch.invalid_total)
    );

    assign out_ch.kind = kind;

endmodule

`default_nettype wire
